[rtl/demurrage_time_adjust_core_defines.svh]
// Assertion macros shared by the demurrage time adjustment RTL.
`ifndef DEMURRAGE_TIME_ADJUST_CORE_DEFINES_SVH
`define DEMURRAGE_TIME_ADJUST_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define DTA_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("dta assertion failed");
`define DTA_ASSERT_NEXT(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("dta assertion failed");
`else
`define DTA_ASSERT(lbl, prop)
`define DTA_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

[rtl/dta_pkg.sv]
// Types, micro-program and ladder tables for the demurrage time adjustment core.
`timescale 1ns / 1ps
package dta_pkg;
   localparam int LadderLen = 26;
   localparam logic [52:0] MaxMoneyReset = 53'h1f_ffff_ffff_ffff;

   typedef enum logic [0:0] {
      REG_BYPASS    = 1'b0,
      REG_MAX_MONEY = 1'b1
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_MUL, ST_FINAL, ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      KIND_PASS, KIND_ZERO, KIND_SAT, KIND_CALC
   } kind_type;

   typedef enum logic [2:0] {
      A_K0, A_K1, A_K2, A_K3, A_V0, A_V1
   } asel_type;

   typedef enum logic [2:0] {
      B_X0, B_X1, B_X2, B_X3, B_W0, B_W1, B_W2, B_W3
   } bsel_type;

   typedef enum logic [1:0] {
      M_LOAD, M_LOADHI, M_ADD, M_NONE
   } mode_type;

   typedef enum logic [2:0] {
      D_NONE, D_W0, D_W1, D_W2, D_W3, D_R0, D_R1
   } dst_type;

   typedef struct packed {
      asel_type a_sel;
      bsel_type b_sel;
      mode_type mode;
      logic     top_only;
      dst_type  dst;
      logic     shift;
      logic     chk;
      logic     last;
   } uop_type;

   function automatic uop_type mk(input asel_type a, input bsel_type b, input mode_type m,
                                  input logic t, input dst_type d, input logic s,
                                  input logic c, input logic l);
      uop_type u;
      u.a_sel = a;
      u.b_sel = b;
      u.mode = m;
      u.top_only = t;
      u.dst = d;
      u.shift = s;
      u.chk = c;
      u.last = l;
      return u;
   endfunction

   function automatic uop_type uop(input logic rev, input logic fin, input logic [3:0] step);
      uop_type u;
      u = mk(A_K0, B_X0, M_NONE, 1'b0, D_NONE, 1'b0, 1'b0, 1'b1);
      case ({rev, fin})
         2'b00: begin
            case (step)
               4'd0: u = mk(A_K1, B_X0, M_LOAD, 1'b0, D_NONE, 1'b0, 1'b0, 1'b0);
               4'd1: u = mk(A_K0, B_X1, M_ADD, 1'b0, D_NONE, 1'b1, 1'b0, 1'b0);
               4'd2: u = mk(A_K0, B_X0, M_ADD, 1'b0, D_W1, 1'b1, 1'b0, 1'b0);
               4'd3: u = mk(A_K0, B_X0, M_NONE, 1'b0, D_W0, 1'b0, 1'b0, 1'b1);
               default: u = mk(A_K0, B_X0, M_NONE, 1'b0, D_NONE, 1'b0, 1'b0, 1'b1);
            endcase
         end
         2'b01: begin
            case (step)
               4'd0: u = mk(A_V1, B_W1, M_LOADHI, 1'b0, D_NONE, 1'b0, 1'b0, 1'b0);
               4'd1: u = mk(A_V0, B_W1, M_ADD, 1'b0, D_NONE, 1'b0, 1'b0, 1'b0);
               4'd2: u = mk(A_V1, B_W0, M_ADD, 1'b0, D_NONE, 1'b1, 1'b0, 1'b0);
               4'd3: u = mk(A_V0, B_W0, M_ADD, 1'b0, D_NONE, 1'b0, 1'b0, 1'b1);
               default: u = mk(A_K0, B_X0, M_NONE, 1'b0, D_NONE, 1'b0, 1'b0, 1'b1);
            endcase
         end
         2'b10: begin
            case (step)
               4'd0:  u = mk(A_K3, B_X2, M_LOAD, 1'b0, D_NONE, 1'b0, 1'b0, 1'b0);
               4'd1:  u = mk(A_K2, B_X3, M_ADD, 1'b0, D_NONE, 1'b1, 1'b0, 1'b0);
               4'd2:  u = mk(A_K3, B_X1, M_ADD, 1'b0, D_NONE, 1'b0, 1'b0, 1'b0);
               4'd3:  u = mk(A_K2, B_X2, M_ADD, 1'b0, D_NONE, 1'b0, 1'b0, 1'b0);
               4'd4:  u = mk(A_K1, B_X3, M_ADD, 1'b0, D_W3, 1'b1, 1'b0, 1'b0);
               4'd5:  u = mk(A_K3, B_X0, M_ADD, 1'b1, D_NONE, 1'b0, 1'b0, 1'b0);
               4'd6:  u = mk(A_K0, B_X3, M_ADD, 1'b1, D_NONE, 1'b0, 1'b0, 1'b0);
               4'd7:  u = mk(A_K2, B_X1, M_ADD, 1'b0, D_NONE, 1'b0, 1'b0, 1'b0);
               4'd8:  u = mk(A_K1, B_X2, M_ADD, 1'b0, D_W2, 1'b1, 1'b0, 1'b0);
               4'd9:  u = mk(A_K2, B_X0, M_ADD, 1'b1, D_NONE, 1'b0, 1'b0, 1'b0);
               4'd10: u = mk(A_K0, B_X2, M_ADD, 1'b1, D_NONE, 1'b0, 1'b0, 1'b0);
               4'd11: u = mk(A_K1, B_X1, M_ADD, 1'b0, D_W1, 1'b1, 1'b0, 1'b0);
               4'd12: u = mk(A_K1, B_X0, M_ADD, 1'b1, D_NONE, 1'b0, 1'b0, 1'b0);
               4'd13: u = mk(A_K0, B_X1, M_ADD, 1'b1, D_W0, 1'b0, 1'b1, 1'b1);
               default: u = mk(A_K0, B_X0, M_NONE, 1'b0, D_NONE, 1'b0, 1'b0, 1'b1);
            endcase
         end
         default: begin
            case (step)
               4'd0: u = mk(A_V1, B_W3, M_LOADHI, 1'b0, D_NONE, 1'b0, 1'b0, 1'b0);
               4'd1: u = mk(A_V1, B_W2, M_ADD, 1'b0, D_NONE, 1'b0, 1'b0, 1'b0);
               4'd2: u = mk(A_V0, B_W3, M_ADD, 1'b0, D_NONE, 1'b1, 1'b0, 1'b0);
               4'd3: u = mk(A_V1, B_W1, M_ADD, 1'b0, D_NONE, 1'b0, 1'b0, 1'b0);
               4'd4: u = mk(A_V0, B_W2, M_ADD, 1'b0, D_R1, 1'b1, 1'b0, 1'b0);
               4'd5: u = mk(A_V1, B_W0, M_ADD, 1'b0, D_NONE, 1'b0, 1'b0, 1'b0);
               4'd6: u = mk(A_V0, B_W1, M_ADD, 1'b0, D_R0, 1'b1, 1'b1, 1'b1);
               default: u = mk(A_K0, B_X0, M_NONE, 1'b0, D_NONE, 1'b0, 1'b0, 1'b1);
            endcase
         end
      endcase
      return u;
   endfunction

   function automatic logic [63:0] fwd_rom(input logic [4:0] b);
      logic [63:0] k;
      case (b)
         5'd0:  k = 64'hfffff000_00000000;
         5'd1:  k = 64'hffffe000_01000000;
         5'd2:  k = 64'hffffc000_05ffffc0;
         5'd3:  k = 64'hffff8000_1bfffc80;
         5'd4:  k = 64'hffff0000_77ffdd00;
         5'd5:  k = 64'hfffe0001_effeca00;
         5'd6:  k = 64'hfffc0007_dff5d409;
         5'd7:  k = 64'hfff8001f_bfaca8a2;
         5'd8:  k = 64'hfff0007f_7d5d5a6a;
         5'd9:  k = 64'hffe001fe_eacb48a8;
         5'd10: k = 64'hffc007fd_55dfda2a;
         5'd11: k = 64'hff801ff6_ad5499cd;
         5'd12: k = 64'hff007fcd_67f98aad;
         5'd13: k = 64'hfe01fe9b_74f0943e;
         5'd14: k = 64'hfc07f540_767d2a82;
         5'd15: k = 64'hf81fab16_3dc15990;
         5'd16: k = 64'hf07d5f65_f9604ac9;
         5'd17: k = 64'he1eb5045_80b6ebf7;
         5'd18: k = 64'hc75f7b66_a5075def;
         5'd19: k = 64'h9b459576_663bbb3e;
         5'd20: k = 64'h5e2d55e7_48e27ab4;
         5'd21: k = 64'h22a5531d_29a95916;
         5'd22: k = 64'h04b054d7_fda49c4d;
         5'd23: k = 64'h0015fc1b_85085be9;
         5'd24: k = 64'h000001e3_54ca043c;
         5'd25: k = 64'h00000000_00039089;
         default: k = 64'h0;
      endcase
      return k;
   endfunction

   function automatic logic [127:0] rev_rom(input logic [4:0] b);
      logic [127:0] k;
      case (b)
         5'd0:  k = 128'h00000000_00000001_00001000_01000010;
         5'd1:  k = 128'h00000000_00000001_00002000_03000040;
         5'd2:  k = 128'h00000000_00000001_00004000_0a000140;
         5'd3:  k = 128'h00000000_00000001_00008000_24000780;
         5'd4:  k = 128'h00000000_00000001_00010000_88003300;
         5'd5:  k = 128'h00000000_00000001_00020002_10017600;
         5'd6:  k = 128'h00000000_00000001_00040008_200b2c0b;
         5'd7:  k = 128'h00000000_00000001_00080020_405758b2;
         5'd8:  k = 128'h00000000_00000001_00100080_82b2baeb;
         5'd9:  k = 128'h00000000_00000001_00200201_15760cb0;
         5'd10: k = 128'h00000000_00000001_00400802_ab357b3b;
         5'd11: k = 128'h00000000_00000001_00802009_5800bbef;
         5'd12: k = 128'h00000000_00000001_01008032_bd5bcef3;
         5'd13: k = 128'h00000000_00000001_02020166_20651cee;
         5'd14: k = 128'h00000000_00000001_04080ad5_dee644e3;
         5'd15: k = 128'h00000000_00000001_08205643_1a97126a;
         5'd16: k = 128'h00000000_00000001_1082b600_14af6333;
         5'd17: k = 128'h00000000_00000001_2216057d_856dd258;
         5'd18: k = 128'h00000000_00000001_48b5e655_53fde431;
         5'd19: k = 128'h00000000_00000001_a6129f7a_2b20cd20;
         5'd20: k = 128'h00000000_00000002_b7e16721_96b730c5;
         5'd21: k = 128'h00000000_00000007_6399a46e_d2eda481;
         5'd22: k = 128'h00000000_00000036_99272f73_36391a9f;
         5'd23: k = 128'h00000000_00000ba4_f827e152_14cd8421;
         5'd24: k = 128'h00000000_008797a2_510309b9_c64e0d7e;
         5'd25: k = 128'h000047d1_470253b0_78e38992_14983b4b;
         default: k = 128'h0;
      endcase
      return k;
   endfunction
endpackage

[rtl/demurrage_time_adjust_core.sv]
// Demurrage time adjustment core: ladder multiply over one shared 32x32 multiplier.
//
// Channel  Direction  Ports                                   Handshake
// req      in         req_amount, req_depth                   start & !busy
// rsp      out        rsp_adjusted_amount, rsp_clamped        rsp_valid strobe, one cycle
// csr      in         csr_index, csr_wdata                    csr_valid & csr_ready
//
// A computed transaction scans the 26-entry ladder, runs a multiply micro-program (4 steps for
// decay, 14 for growth) for each further set depth bit and then a 4 or 7 step final product,
// all on the single multiplier and accumulator, with entry and exit states around them.
// Bypass, zero depth and out-of-range transactions go straight from idle to the done state.
// Reset is synchronous: it idles the sequencer, clears bypass and rsp_valid and sets max money to all ones.
// The result is driven for one cycle; the receiver cannot stall it.
`timescale 1ns / 1ps
`include "demurrage_time_adjust_core_defines.svh"
module demurrage_time_adjust_core
   import dta_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [53:0] req_amount,
   input  logic signed [31:0] req_depth,
   output logic               rsp_valid,
   output logic signed [53:0] rsp_adjusted_amount,
   output logic               rsp_clamped,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [0:0]         csr_index,
   input  logic [52:0]        csr_wdata
);
   state_type state_ff, state_in;
   kind_type kind_ff;
   logic bypass_ff;
   logic [52:0] max_ff;
   logic [53:0] raw_ff, mag_ff;
   logic neg_ff, rev_ff, first_ff, sat_ff;
   logic [31:0] dist_ff;
   logic [4:0] b_ff;
   logic [3:0] step_ff;
   logic [31:0] w_ff [4];
   logic [31:0] x_ff [4];
   logic [31:0] r0_ff, r1_ff;
   logic [71:0] acc_ff;
   logic rsp_valid_ff, rsp_clamped_ff;
   logic [53:0] rsp_amount_ff;

   logic accept;
   logic [53:0] in_mag;
   logic [31:0] in_dist;
   kind_type in_kind;
   logic [63:0] fk;
   logic [127:0] rk;
   logic [31:0] k [4];
   uop_type u;
   logic is_top, bit_set;
   logic [31:0] a_op, b_op;
   logic [63:0] prod, addend;
   logic [71:0] sum, base;
   logic hit;
   logic [63:0] val, res, neg_res;
   logic res_clamp;

   assign accept = start && (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign in_mag = req_amount[53] ? (54'd0 - req_amount) : req_amount;
   assign in_dist = req_depth[31] ? (32'd0 - req_depth) : req_depth;

   always_comb begin
      if (bypass_ff || req_depth == 32'sd0) begin
         in_kind = KIND_PASS;
      end else if (req_depth[31]) begin
         if (in_mag == 54'd0) begin
            in_kind = KIND_ZERO;
         end else if (in_dist[31:26] != 6'd0) begin
            in_kind = KIND_SAT;
         end else begin
            in_kind = KIND_CALC;
         end
      end else if (in_dist[31:26] != 6'd0) begin
         in_kind = KIND_ZERO;
      end else begin
         in_kind = KIND_CALC;
      end
   end

   assign fk = fwd_rom(b_ff);
   assign rk = rev_rom(b_ff);
   assign k[0] = rev_ff ? rk[127:96] : fk[63:32];
   assign k[1] = rev_ff ? rk[95:64] : fk[31:0];
   assign k[2] = rk[63:32];
   assign k[3] = rk[31:0];
   assign is_top = (b_ff == 5'(LadderLen - 1));
   assign bit_set = dist_ff[b_ff];

   always_comb begin
      u = uop(rev_ff, state_ff == ST_FINAL, step_ff);
      case (u.a_sel)
         A_K0: a_op = k[0];
         A_K1: a_op = k[1];
         A_K2: a_op = k[2];
         A_K3: a_op = k[3];
         A_V0: a_op = {10'd0, mag_ff[53:32]};
         A_V1: a_op = mag_ff[31:0];
         default: a_op = 32'd0;
      endcase
      case (u.b_sel)
         B_X0: b_op = x_ff[0];
         B_X1: b_op = x_ff[1];
         B_X2: b_op = x_ff[2];
         B_X3: b_op = x_ff[3];
         B_W0: b_op = w_ff[0];
         B_W1: b_op = w_ff[1];
         B_W2: b_op = w_ff[2];
         B_W3: b_op = w_ff[3];
         default: b_op = 32'd0;
      endcase
      prod = a_op * b_op;
      if (u.mode == M_NONE || (u.top_only && !is_top)) begin
         addend = 64'd0;
      end else if (u.mode == M_LOADHI) begin
         addend = {32'd0, prod[63:32]};
      end else begin
         addend = prod;
      end
      base = (u.mode == M_LOAD || u.mode == M_LOADHI) ? 72'd0 : acc_ff;
      sum = base + {8'd0, addend};
      if (state_ff == ST_MUL) begin
         hit = u.chk && is_top && (sum[71:32] != 40'd0 || x_ff[0] != 32'd0);
      end else begin
         hit = u.chk && (sum[71:32] != 40'd0 || (mag_ff[53:32] != 22'd0 && w_ff[0] != 32'd0));
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = (in_kind == KIND_CALC) ? ST_SCAN : ST_DONE;
            end
         end
         ST_SCAN: begin
            if (b_ff == 5'(LadderLen)) begin
               state_in = ST_FINAL;
            end else if (bit_set && !first_ff) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (u.last) begin
               state_in = hit ? ST_DONE : ST_SCAN;
            end
         end
         ST_FINAL: begin
            if (u.last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      busy = (state_ff != ST_IDLE);
      val = {r0_ff, r1_ff};
      res_clamp = 1'b0;
      res = 64'd0;
      case (kind_ff)
         KIND_PASS: res = {10'd0, raw_ff};
         KIND_ZERO: res = 64'd0;
         KIND_SAT: res_clamp = 1'b1;
         KIND_CALC: begin
            if (!rev_ff) begin
               res = acc_ff[63:0];
            end else if (sat_ff || val > {11'd0, max_ff}) begin
               res_clamp = 1'b1;
            end else begin
               res = val;
            end
         end
         default: res = 64'd0;
      endcase
      if (res_clamp) begin
         res = {11'd0, max_ff};
      end
      neg_res = 64'd0 - res;
      if (kind_ff == KIND_PASS) begin
         neg_res = res;
      end else if (neg_ff) begin
         res = neg_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         bypass_ff <= 1'b0;
         max_ff <= MaxMoneyReset;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= (state_ff == ST_DONE);
         if (csr_valid && csr_ready) begin
            case (reg_index_type'(csr_index))
               REG_BYPASS: bypass_ff <= csr_wdata[0];
               REG_MAX_MONEY: max_ff <= csr_wdata;
               default: bypass_ff <= bypass_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         raw_ff <= req_amount;
         mag_ff <= in_mag;
         neg_ff <= req_amount[53];
         rev_ff <= req_depth[31];
         dist_ff <= in_dist;
         kind_ff <= in_kind;
         b_ff <= 5'd0;
         first_ff <= 1'b1;
         sat_ff <= 1'b0;
         step_ff <= 4'd0;
         w_ff[0] <= 32'd0;
         w_ff[1] <= 32'd1;
         w_ff[2] <= 32'd0;
         w_ff[3] <= 32'd0;
      end
      case (state_ff)
         ST_SCAN: begin
            step_ff <= 4'd0;
            if (b_ff != 5'(LadderLen)) begin
               if (bit_set && first_ff) begin
                  first_ff <= 1'b0;
                  b_ff <= b_ff + 5'd1;
                  for (int i = 0; i < 4; i++) begin
                     w_ff[i] <= k[i];
                  end
               end else if (bit_set) begin
                  for (int i = 0; i < 4; i++) begin
                     x_ff[i] <= w_ff[i];
                  end
               end else begin
                  b_ff <= b_ff + 5'd1;
               end
            end
         end
         ST_MUL, ST_FINAL: begin
            step_ff <= step_ff + 4'd1;
            acc_ff <= u.shift ? {32'd0, sum[71:32]} : sum;
            case (u.dst)
               D_W0: w_ff[0] <= sum[31:0];
               D_W1: w_ff[1] <= sum[31:0];
               D_W2: w_ff[2] <= sum[31:0];
               D_W3: w_ff[3] <= sum[31:0];
               D_R0: r0_ff <= sum[31:0];
               D_R1: r1_ff <= sum[31:0];
               default: r0_ff <= r0_ff;
            endcase
            if (hit) begin
               sat_ff <= 1'b1;
            end
            if (u.last && state_ff == ST_MUL) begin
               b_ff <= b_ff + 5'd1;
            end
         end
         ST_DONE: begin
            rsp_amount_ff <= res[53:0];
            rsp_clamped_ff <= res_clamp;
         end
         default: step_ff <= step_ff;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_adjusted_amount = rsp_amount_ff;
   assign rsp_clamped = rsp_clamped_ff;

   logic [53:0] max_pos, max_neg;
   logic clamp_ok;
   assign max_pos = {1'b0, max_ff};
   assign max_neg = 54'd0 - max_pos;
   assign clamp_ok = (rsp_adjusted_amount == max_pos) || (rsp_adjusted_amount == max_neg);

   `DTA_ASSERT_NEXT(a_accept_busy, accept, busy)
   `DTA_ASSERT(a_rsp_after_done, rsp_valid |-> $past(state_ff == ST_DONE))
   `DTA_ASSERT(a_clamp_value, (rsp_valid && rsp_clamped) |-> clamp_ok)
   `DTA_ASSERT(a_mul_after_first, (state_ff == ST_MUL) |-> !first_ff)
endmodule
